// ===== sv/tterm_pkg.sv =====
`default_nettype none

package tterm_pkg;

	// Character codes the parser reacts to.
	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_SGR      = 8'h6D;
	localparam logic [7:0] CH_CLEAR    = 8'h4A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_DIGIT0   = 8'h30;
	localparam logic [7:0] CH_DIGIT9   = 8'h39;

	// SGR parameter values and attribute bytes.
	localparam logic [6:0] SGR_RESET    = 7'd0;
	localparam logic [6:0] SGR_FG_FIRST = 7'd30;
	localparam logic [6:0] SGR_FG_LAST  = 7'd37;
	localparam logic [6:0] PARAM_MAX    = 7'd99;
	localparam logic [7:0] ATTR_RESET   = 8'd15;
	localparam logic [7:0] ATTR_GREY    = 8'd7;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_CSI    = 2'd2
	} esc_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCROLL,
		ST_CLEAR,
		ST_PUT,
		ST_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic read;
		logic parse;
		logic put;
		logic sweep_start;
		logic scroll_step;
		logic clear_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_read;
		logic is_special;
		logic is_clear;
		logic at_end;
		logic sweep_last;
	} dp_status_t;

	// Standard VGA palette order for SGR foreground codes 30 through 37.
	function automatic logic [7:0] sgr_color(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'd0;
			3'd1:    c = 8'd4;
			3'd2:    c = 8'd2;
			3'd3:    c = 8'd6;
			3'd4:    c = 8'd1;
			3'd5:    c = 8'd5;
			3'd6:    c = 8'd3;
			default: c = 8'd15;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== sv/tterm_ctrl.sv =====
`default_nettype none

module tterm_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  out_stall,
	input  wire tterm_pkg::dp_status_t sts,
	output logic                       in_stall,
	output logic                       out_valid,
	output tterm_pkg::dp_cmd_t         cmd
);

	tterm_pkg::ctrl_state_t state_q, state_nx;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tterm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			tterm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = tterm_pkg::ST_DECODE;
				end
			end
			tterm_pkg::ST_DECODE: begin
				if (sts.is_read) begin
					cmd.read = 1'b1;
					state_nx = tterm_pkg::ST_RESULT;
				end else if (sts.is_clear) begin
					cmd.parse       = 1'b1;
					cmd.sweep_start = 1'b1;
					state_nx        = tterm_pkg::ST_CLEAR;
				end else if (sts.is_special) begin
					cmd.parse = 1'b1;
					state_nx  = tterm_pkg::ST_RESULT;
				end else if (sts.at_end) begin
					cmd.sweep_start = 1'b1;
					state_nx        = tterm_pkg::ST_SCROLL;
				end else begin
					cmd.put  = 1'b1;
					state_nx = tterm_pkg::ST_RESULT;
				end
			end
			tterm_pkg::ST_SCROLL: begin
				cmd.scroll_step = 1'b1;
				if (sts.sweep_last) begin
					state_nx = tterm_pkg::ST_PUT;
				end
			end
			tterm_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.sweep_last) begin
					state_nx = tterm_pkg::ST_RESULT;
				end
			end
			tterm_pkg::ST_PUT: begin
				cmd.put  = 1'b1;
				state_nx = tterm_pkg::ST_RESULT;
			end
			tterm_pkg::ST_RESULT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					in_stall     = 1'b0;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_nx = tterm_pkg::ST_DECODE;
					end else begin
						state_nx = tterm_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nx = tterm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/tterm_dp.sv =====
`default_nettype none

module tterm_dp #(
	parameter int COLUMNS     = 80,
	parameter int ROWS        = 25,
	parameter int TAB_STOP    = 4,
	parameter int PARAM_LIMIT = 15
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tterm_pkg::dp_cmd_t    cmd,
	input  wire logic                  action,
	input  wire logic [7:0]            char_code,
	input  wire logic [10:0]           cell_address,
	output tterm_pkg::dp_status_t      sts,
	output logic [15:0]                cell_data,
	output logic [10:0]                cursor_now,
	output logic [7:0]                 color_now,
	output logic [1:0]                 parser_mode
);

	localparam int CELLS   = COLUMNS * ROWS;
	localparam int CW      = $clog2(CELLS + 1);
	localparam int AW      = $clog2(CELLS);
	localparam int XW      = CW + 11;
	localparam int COLW    = $clog2(COLUMNS);
	localparam int CXW     = $clog2(COLUMNS + 16);
	localparam int TW      = $clog2(TAB_STOP + 1);
	localparam int PCW     = $clog2(PARAM_LIMIT + 1);
	localparam int COL_TAB = COLUMNS % TAB_STOP;
	localparam int END_TAB = CELLS % TAB_STOP;
	localparam int SCR_TAB = (CELLS - COLUMNS) % TAB_STOP;

	function automatic logic [TW-1:0] tab_wrap(input logic [TW:0] x);
		logic [TW:0] r;
		r = (x >= (TW+1)'(TAB_STOP)) ? x - (TW+1)'(TAB_STOP) : x;
		return r[TW-1:0];
	endfunction

	// Item registers.
	logic        action_q;
	logic [7:0]  char_q;
	logic [10:0] addr_q;

	// Terminal state.
	logic [CW-1:0]        cursor_q;
	logic [COLW-1:0]      col_q;
	logic [TW-1:0]        tab_q;
	logic [TW-1:0]        rowtab_q;
	logic [7:0]           attr_q;
	tterm_pkg::esc_mode_t mode_q;
	logic [PCW-1:0]       pchars_q;
	logic [6:0]           pval_q;
	logic                 pended_q;
	logic [CW-1:0]        sweep_q;

	// Screen memory.
	logic [15:0] mem_q [CELLS];
	logic [15:0] rdata_q;
	logic        mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [15:0] mem_wd;

	// Result register.
	logic [15:0] cell_data_q;
	logic [10:0] cursor_now_q;
	logic [7:0]  color_now_q;
	logic [1:0]  parser_mode_q;

	logic          is_digit, is_param, is_nl, is_tab;
	logic [9:0]    pval_prod;
	logic [6:0]    pval_nx;
	logic [7:0]    attr_sgr;
	logic [XW-1:0] addr_w, cur_w;
	logic          in_range;
	logic [15:0]   blank;
	logic [CXW-1:0] step, col_sum, col_a, col_b;
	logic [TW-1:0] rt_a, rt_b, tab_nx;
	logic [CW:0]   cur_sum;
	logic          sat;
	logic [CW-1:0] scroll_src;

	assign is_digit = char_q inside {[tterm_pkg::CH_DIGIT0:tterm_pkg::CH_DIGIT9]};
	assign is_param = is_digit || (char_q == tterm_pkg::CH_SEMI);
	assign is_nl    = (char_q == tterm_pkg::CH_NL);
	assign is_tab   = (char_q == tterm_pkg::CH_TAB);
	assign blank    = {attr_q, tterm_pkg::CH_SPACE};
	assign addr_w   = XW'(addr_q);
	assign cur_w    = XW'(cursor_q);
	assign in_range = addr_w < XW'(CELLS);

	// Decimal accumulation: value * 10 + digit, saturated.
	assign pval_prod = {pval_q, 3'b000} + 10'({pval_q, 1'b0}) + 10'(char_q[3:0]);
	assign pval_nx   = (pval_prod > 10'(tterm_pkg::PARAM_MAX)) ? tterm_pkg::PARAM_MAX
		: pval_prod[6:0];

	always_comb begin
		attr_sgr = attr_q;
		if (pval_q == tterm_pkg::SGR_RESET) begin
			attr_sgr = tterm_pkg::ATTR_GREY;
		end else if (pval_q inside {[tterm_pkg::SGR_FG_FIRST:tterm_pkg::SGR_FG_LAST]}) begin
			attr_sgr = tterm_pkg::sgr_color(3'(pval_q - tterm_pkg::SGR_FG_FIRST));
		end
	end

	// Cursor advance; the column and tab phase are kept alongside the cursor.
	always_comb begin
		if (is_nl) begin
			step = CXW'(COLUMNS) - CXW'(col_q);
		end else if (is_tab) begin
			step = CXW'(TAB_STOP) - CXW'(tab_q);
		end else begin
			step = CXW'(1);
		end
		col_sum = CXW'(col_q) + step;
		col_a   = col_sum;
		rt_a    = rowtab_q;
		if (col_sum >= CXW'(COLUMNS)) begin
			col_a = col_sum - CXW'(COLUMNS);
			rt_a  = tab_wrap({1'b0, rowtab_q} + (TW+1)'(COL_TAB));
		end
		col_b = col_a;
		rt_b  = rt_a;
		if (col_a >= CXW'(COLUMNS)) begin
			col_b = col_a - CXW'(COLUMNS);
			rt_b  = tab_wrap({1'b0, rt_a} + (TW+1)'(COL_TAB));
		end
		if (is_nl) begin
			tab_nx = rt_b;
		end else if (is_tab) begin
			tab_nx = '0;
		end else begin
			tab_nx = tab_wrap({1'b0, tab_q} + (TW+1)'(1));
		end
		cur_sum = {1'b0, cursor_q} + (CW+1)'(step);
		sat     = cur_sum > (CW+1)'(CELLS);
	end

	// Memory port selection.
	assign scroll_src = sweep_q + CW'(COLUMNS);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cursor_q[AW-1:0];
		mem_wd = {attr_q, char_q};
		mem_re = 1'b0;
		mem_ra = addr_w[AW-1:0];
		if (cmd.put) begin
			mem_we = !is_nl && !is_tab;
		end else if (cmd.scroll_step || cmd.clear_step) begin
			mem_we = (sweep_q != '0);
			mem_wa = AW'(sweep_q - CW'(1));
			mem_wd = (cmd.scroll_step && (sweep_q <= CW'(CELLS - COLUMNS))) ? rdata_q : blank;
		end
		if (cmd.read) begin
			mem_re = 1'b1;
		end else if (cmd.scroll_step) begin
			mem_re = sweep_q < CW'(CELLS - COLUMNS);
			mem_ra = scroll_src[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			char_q   <= char_code;
			addr_q   <= cell_address;
		end
		if (cmd.out_load) begin
			cell_data_q   <= (action_q && in_range) ? rdata_q : 16'd0;
			cursor_now_q  <= cur_w[10:0];
			color_now_q   <= attr_q;
			parser_mode_q <= mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			col_q    <= '0;
			tab_q    <= '0;
			rowtab_q <= '0;
			attr_q   <= tterm_pkg::ATTR_RESET;
			mode_q   <= tterm_pkg::MODE_NORMAL;
			pchars_q <= '0;
			pval_q   <= '0;
			pended_q <= 1'b0;
			sweep_q  <= '0;
		end else begin
			if (cmd.parse) begin
				case (mode_q)
					tterm_pkg::MODE_ESC: begin
						if (char_q == tterm_pkg::CH_LBRACKET) begin
							mode_q   <= tterm_pkg::MODE_CSI;
							pchars_q <= '0;
							pval_q   <= '0;
							pended_q <= 1'b0;
						end else begin
							mode_q <= tterm_pkg::MODE_NORMAL;
						end
					end
					tterm_pkg::MODE_CSI: begin
						if (is_param) begin
							if (pchars_q < PCW'(PARAM_LIMIT)) begin
								pchars_q <= pchars_q + PCW'(1);
								if (!pended_q) begin
									if (is_digit) begin
										pval_q <= pval_nx;
									end else begin
										pended_q <= 1'b1;
									end
								end
							end
						end else begin
							if (char_q == tterm_pkg::CH_SGR) begin
								attr_q <= attr_sgr;
							end
							mode_q <= tterm_pkg::MODE_NORMAL;
						end
					end
					default: begin
						if (char_q == tterm_pkg::CH_ESC) begin
							mode_q <= tterm_pkg::MODE_ESC;
						end
					end
				endcase
			end
			if (cmd.put) begin
				if (sat) begin
					cursor_q <= CW'(CELLS);
					col_q    <= '0;
					tab_q    <= TW'(END_TAB);
					rowtab_q <= TW'(END_TAB);
				end else begin
					cursor_q <= cur_sum[CW-1:0];
					col_q    <= col_b[COLW-1:0];
					tab_q    <= tab_nx;
					rowtab_q <= rt_b;
				end
			end
			if (cmd.sweep_start) begin
				sweep_q <= '0;
			end else if (cmd.scroll_step || cmd.clear_step) begin
				sweep_q <= sweep_q + CW'(1);
			end
			if (cmd.scroll_step && sts.sweep_last) begin
				cursor_q <= CW'(CELLS - COLUMNS);
				col_q    <= '0;
				tab_q    <= TW'(SCR_TAB);
				rowtab_q <= TW'(SCR_TAB);
			end
			if (cmd.clear_step && sts.sweep_last) begin
				cursor_q <= '0;
				col_q    <= '0;
				tab_q    <= '0;
				rowtab_q <= '0;
			end
		end
	end

	always_comb begin
		sts.is_read    = action_q;
		sts.is_special = (mode_q != tterm_pkg::MODE_NORMAL) || (char_q == tterm_pkg::CH_ESC);
		sts.is_clear   = (mode_q == tterm_pkg::MODE_CSI) && (char_q == tterm_pkg::CH_CLEAR);
		sts.at_end     = cursor_q >= CW'(CELLS);
		sts.sweep_last = sweep_q == CW'(CELLS);
	end

	assign cell_data   = cell_data_q;
	assign cursor_now  = cursor_now_q;
	assign color_now   = color_now_q;
	assign parser_mode = parser_mode_q;

endmodule

`default_nettype wire

// ===== sv/text_terminal_with_ansi_color.sv =====
// Text-mode terminal with ANSI color. Each input beat either puts one character byte
// through an ESC / ESC-[ parser (action 0) or reads one screen cell (action 1), and
// every input beat yields exactly one output beat carrying the read cell (zero for a
// put or an address past the last cell), the cursor, the current attribute and the
// parser mode after the item. The screen is a COLUMNS x ROWS cell memory with one
// write port and one read port, so at most one cell is written and one cell read per
// cycle. A read or an ordinary put passes through a decode state and a result state,
// and the next beat is already taken in the result state once the output is free.
// Writing past the last cell first scrolls the screen with a sweep through the
// memory before the put; ESC [ J blanks every cell in a similar sweep.
// Cells never written since reset read back as arbitrary data.
`default_nettype none

module text_terminal_with_ansi_color #(
	parameter int COLUMNS     = 80,
	parameter int ROWS        = 25,
	parameter int TAB_STOP    = 4,
	parameter int PARAM_LIMIT = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input channel.
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [7:0]  char_code,
	input  wire logic [10:0] cell_address,
	// Output channel.
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      cell_data,
	output logic [10:0]      cursor_now,
	output logic [7:0]       color_now,
	output logic [1:0]       parser_mode
);

	// The controller sequences decode, screen sweeps and the result register; the
	// datapath owns the screen memory, cursor, attribute and escape parser state.
	tterm_pkg::dp_cmd_t    cmd;
	tterm_pkg::dp_status_t sts;

	tterm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	tterm_dp #(
		.COLUMNS     (COLUMNS),
		.ROWS        (ROWS),
		.TAB_STOP    (TAB_STOP),
		.PARAM_LIMIT (PARAM_LIMIT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (action),
		.char_code    (char_code),
		.cell_address (cell_address),
		.sts          (sts),
		.cell_data    (cell_data),
		.cursor_now   (cursor_now),
		.color_now    (color_now),
		.parser_mode  (parser_mode)
	);

	// The memory has one write port: a put and a sweep step never coincide, and a
	// read is never issued alongside either.
	a_one_mem_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.read, cmd.put, cmd.scroll_step, cmd.clear_step}))
		else $error("more than one memory operation in a cycle");

	// No new beat is taken while the screen is being swept.
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scroll_step || cmd.clear_step) |-> in_stall)
		else $error("input accepted during a screen sweep");

	// The memory read is registered, and in the cycle after it the result loads or waits.
	a_read_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |=> (cmd.out_load || (out_valid && out_stall)))
		else $error("read result not presented after the memory read");

endmodule

`default_nettype wire
